// ----- sv/svpwm_ss_pkg.sv -----
`default_nettype none
package svpwm_ss_pkg;

    localparam int FULL_PERIOD = 16384;
    localparam int SQRT3_Q14   = 28378;

    localparam int CFG_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 176;

    // divider geometry: quotient bits, divisor bits
    localparam int DIV_QW  = 15;
    localparam int DIV_DW  = 21;
    // time and post-processing widths
    localparam int TW      = 22;
    localparam int PW      = 26;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_LEAD   = 2'd2;

    localparam logic [CFG_W-1:0] MAX_DUTY_RST = 15'd16384;

    function automatic logic [1:0] edge_sel(input logic [1:0] ph, input logic [2:0] sec);
        logic [1:0] r;
        r = 2'd0;
        unique case (ph)
            2'd0: begin
                unique case (sec) inside
                    3'd1, 3'd6: r = 2'd1;
                    3'd4, 3'd5: r = 2'd2;
                    default:    r = 2'd0;
                endcase
            end
            2'd1: begin
                unique case (sec) inside
                    3'd3, 3'd4: r = 2'd1;
                    3'd2, 3'd6: r = 2'd2;
                    default:    r = 2'd0;
                endcase
            end
            2'd2: begin
                unique case (sec) inside
                    3'd2, 3'd5: r = 2'd1;
                    3'd1, 3'd3: r = 2'd2;
                    default:    r = 2'd0;
                endcase
            end
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sat_s16(input logic signed [PW-1:0] v);
        logic [15:0] r;
        if (v > $signed(PW'(32767))) begin
            r = 16'h7fff;
        end else if (v < -$signed(PW'(32768))) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [14:0] sat_u15(input logic signed [PW-1:0] v);
        logic [14:0] r;
        if (v > $signed(PW'(32767))) begin
            r = 15'h7fff;
        end else if (v < 0) begin
            r = 15'h0;
        end else begin
            r = v[14:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/svpwm_ss_div.sv -----
`default_nettype none
module svpwm_ss_div #(
    parameter int QW = 15,
    parameter int DW = 21,
    parameter int SW = 46
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [DW+QW-1:0]   in_dividend,
    input  wire logic [DW-1:0]      in_divisor,
    input  wire logic [SW-1:0]      in_side,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [QW-1:0]           out_quot,
    output logic [SW-1:0]           out_side
);
    // one restoring step per stage; dividend must be below divisor << QW

    logic          v_reg   [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] dvs_reg [QW];
    logic [SW-1:0] side_reg[QW];
    logic [QW:0]   rdy;

    assign rdy[QW] = out_ready;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem;
        logic [QW-1:0] p_lo;
        logic [QW-1:0] p_q;
        logic [DW-1:0] p_dvs;
        logic [SW-1:0] p_side;
        logic [DW:0]   r2;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign p_v    = in_valid;
            assign p_rem  = in_dividend[DW+QW-1:QW];
            assign p_lo   = in_dividend[QW-1:0];
            assign p_q    = '0;
            assign p_dvs  = in_divisor;
            assign p_side = in_side;
        end else begin : g_rest
            assign p_v    = v_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_lo   = lo_reg[k-1];
            assign p_q    = q_reg[k-1];
            assign p_dvs  = dvs_reg[k-1];
            assign p_side = side_reg[k-1];
        end

        assign rdy[k]   = !v_reg[k] || rdy[k+1];
        assign r2       = {p_rem, p_lo[QW-1]};
        assign ge       = r2 >= {1'b0, p_dvs};
        assign rem_next = ge ? DW'(r2 - {1'b0, p_dvs}) : r2[DW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= p_v;
            end
            if (rdy[k]) begin
                rem_reg[k]  <= rem_next;
                lo_reg[k]   <= {p_lo[QW-2:0], 1'b0};
                q_reg[k]    <= {p_q[QW-2:0], ge};
                dvs_reg[k]  <= p_dvs;
                side_reg[k] <= p_side;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[QW-1];
    assign out_quot  = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

// ----- sv/svpwm_single_shunt_phase_shift_top.sv -----
// Pipeline: 4 front stages, 15 divider stages and 3 output stages.
// Throughput: one item per cycle when not stalled; a stage advances when empty
// or when its successor advances, so a stalled output still lets bubbles fill.
// Reset: aresetn synchronous active low; clears all valid bits and loads the
// register defaults (max_duty 16384, min_window 0, adc_lead 0).
`default_nettype none
module svpwm_single_shunt_phase_shift_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [15:0] u_alpha, [31:16] u_beta, [46:32] inv_vbus, [47] zero
    input  wire logic [svpwm_ss_pkg::IN_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [2:0] sector, [18:3] adc_trig_first, [34:19] adc_trig_second,
    // [50:35] up_a, [66:51] up_b, [82:67] up_c, [98:83] down_a,
    // [114:99] down_b, [130:115] down_c, [145:131] duty_a,
    // [160:146] duty_b, [175:161] duty_c
    output logic [svpwm_ss_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [svpwm_ss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [svpwm_ss_pkg::CFG_W-1:0]    cfg_wdata
);
    import svpwm_ss_pkg::*;

    localparam int SW = 1 + 2*(DIV_DW) + 3;

    logic [CFG_W-1:0] max_duty_reg, min_window_reg, adc_lead_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_duty_reg   <= MAX_DUTY_RST;
            min_window_reg <= '0;
            adc_lead_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_DUTY:   max_duty_reg   <= cfg_wdata;
                REG_MIN_WINDOW: min_window_reg <= cfg_wdata;
                REG_ADC_LEAD:   adc_lead_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [TW-1:0] mx_s, mn_s;
    assign mx_s = $signed({{(TW-CFG_W){1'b0}}, max_duty_reg});
    assign mn_s = $signed({{(TW-CFG_W){1'b0}}, min_window_reg});

    // ready chain
    logic rdy1, rdy2, rdy3, rdy4, div_in_ready, div_out_valid;
    logic rdy5, rdy6, rdy7;

    // stage 1: scaled beta, tripled alpha
    logic               v1_reg;
    logic signed [17:0] s_reg, a3_reg;
    logic [14:0]        inv1_reg;
    logic signed [15:0] in_a, in_b;
    logic signed [31:0] sb_prod;

    assign in_a    = $signed(s_tdata[15:0]);
    assign in_b    = $signed(s_tdata[31:16]);
    assign sb_prod = in_b * $signed(16'(SQRT3_Q14));
    assign rdy1    = !v1_reg || rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
        if (rdy1) begin
            s_reg    <= 18'(sb_prod >>> 14);
            a3_reg   <= 18'(in_a) + 18'(in_a) + 18'(in_a);
            inv1_reg <= s_tdata[46:32];
        end
    end

    // stage 2: projection products
    logic               v2_reg;
    logic signed [33:0] p1_reg;
    logic signed [34:0] p2_reg, p3_reg;
    logic signed [18:0] d2, d3;
    logic signed [15:0] inv_s;

    assign inv_s = $signed({1'b0, inv1_reg});
    assign d2    = 19'(a3_reg) - 19'(s_reg);
    assign d3    = -19'(a3_reg) - 19'(s_reg);
    assign rdy2  = !v2_reg || rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2) begin
            p1_reg <= s_reg * inv_s;
            p2_reg <= d2 * inv_s;
            p3_reg <= d3 * inv_s;
        end
    end

    // stage 3: sector and active times
    logic                 v3_reg;
    logic [2:0]           sec3_reg;
    logic signed [TW-1:0] t1_3_reg, t2_3_reg;
    logic                 nd3_reg;
    logic signed [TW-1:0] u1, u2, u3, t1_next, t2_next, sum_next;
    logic [2:0]           sec_next;

    assign u1 = TW'(p1_reg >>> 14);
    assign u2 = TW'(p2_reg >>> 15);
    assign u3 = TW'(p3_reg >>> 15);
    assign sec_next = {u3 > 0, u2 > 0, u1 > 0};

    always_comb begin
        t1_next = '0;
        t2_next = '0;
        unique case (sec_next)
            3'd3: begin t1_next = u2;  t2_next = u1;  end
            3'd1: begin t1_next = -u2; t2_next = -u3; end
            3'd5: begin t1_next = u1;  t2_next = u3;  end
            3'd4: begin t1_next = -u1; t2_next = -u2; end
            3'd6: begin t1_next = u3;  t2_next = u2;  end
            3'd2: begin t1_next = -u3; t2_next = -u1; end
            default: ;
        endcase
    end

    assign sum_next = t1_next + t2_next;
    assign rdy3 = !v3_reg || rdy4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
        if (rdy3) begin
            sec3_reg <= sec_next;
            t1_3_reg <= t1_next;
            t2_3_reg <= t2_next;
            nd3_reg  <= (sum_next > mx_s) && (sum_next > 0);
        end
    end

    // keep sum alongside for the divisor
    logic [DIV_DW-1:0] sum3_reg;
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            sum3_reg <= sum_next[DIV_DW-1:0];
        end
    end

    // stage 4: dividend, divisor and side data
    logic                     v4_reg;
    logic [DIV_DW+DIV_QW-1:0] dvd4_reg;
    logic [DIV_DW-1:0]        dvs4_reg;
    logic [SW-1:0]            side4_reg;

    assign rdy4 = !v4_reg || div_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
        if (rdy4) begin
            dvd4_reg  <= nd3_reg ? (DIV_DW+DIV_QW)'(max_duty_reg * t1_3_reg[DIV_DW-2:0]) : '0;
            dvs4_reg  <= nd3_reg ? sum3_reg : DIV_DW'(1);
            side4_reg <= {nd3_reg, t2_3_reg[DIV_DW-1:0], t1_3_reg[DIV_DW-1:0], sec3_reg};
        end
    end

    logic [DIV_QW-1:0] quot;
    logic [SW-1:0]     side_o;

    svpwm_ss_div #(
        .QW (DIV_QW),
        .DW (DIV_DW),
        .SW (SW)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v4_reg),
        .in_ready    (div_in_ready),
        .in_dividend (dvd4_reg),
        .in_divisor  (dvs4_reg),
        .in_side     (side4_reg),
        .out_valid   (div_out_valid),
        .out_ready   (rdy5),
        .out_quot    (quot),
        .out_side    (side_o)
    );

    // stage 5: final times
    logic                 v5_reg;
    logic [2:0]           sec5_reg;
    logic signed [TW-1:0] t1_5_reg, t2_5_reg;
    logic                 nd_o;
    logic signed [TW-1:0] t1_o, t2_o, q_s;

    assign nd_o = side_o[SW-1];
    assign t1_o = TW'($signed(side_o[3 +: DIV_DW]));
    assign t2_o = TW'($signed(side_o[3+DIV_DW +: DIV_DW]));
    assign q_s  = $signed({{(TW-DIV_QW){1'b0}}, quot});
    assign rdy5 = !v5_reg || rdy6;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (rdy5) begin
            v5_reg <= div_out_valid;
        end
        if (rdy5) begin
            sec5_reg <= side_o[2:0];
            t1_5_reg <= nd_o ? q_s : t1_o;
            t2_5_reg <= nd_o ? (mx_s - q_s) : t2_o;
        end
    end

    // stage 6: edges, centres, window shifts
    logic                 v6_reg;
    logic [2:0]           sec6_reg;
    logic signed [PW-1:0] edge_reg [3];
    logic signed [PW-1:0] dl_reg   [3];
    logic signed [PW-1:0] cen_reg  [3];
    logic signed [PW-1:0] t1w, t2w, mnw, x, e0, e1, e2, c2, c1, c0;
    logic signed [PW-1:0] dl_next [3];
    logic                 lt1, lt2;

    assign t1w = PW'(t1_5_reg);
    assign t2w = PW'(t2_5_reg);
    assign mnw = PW'(mn_s);
    assign x   = PW'(FULL_PERIOD) - t1w - t2w;
    assign e0  = x >>> 2;
    assign e1  = e0 + (t1w >>> 1);
    assign e2  = e1 + (t2w >>> 1);
    assign c2  = x >>> 1;
    assign c1  = c2 + t2w;
    assign c0  = c1 + t1w;
    assign lt1 = t1w < mnw;
    assign lt2 = t2w < mnw;

    always_comb begin
        dl_next[0] = '0;
        dl_next[1] = '0;
        dl_next[2] = '0;
        if (lt1 && lt2) begin
            dl_next[0] = (mnw - t1w) >>> 1;
            dl_next[2] = -((mnw - t2w) >>> 1);
        end else if (lt1) begin
            dl_next[0] = (mnw - t1w) >>> 2;
            dl_next[1] = -((mnw - t1w) >>> 2);
            dl_next[2] = -((mnw - t1w) >>> 2);
        end else if (lt2) begin
            dl_next[0] = (mnw - t2w) >>> 2;
            dl_next[1] = (mnw - t2w) >>> 2;
            dl_next[2] = -((mnw - t2w) >>> 2);
        end
    end

    assign rdy6 = !v6_reg || rdy7;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (rdy6) begin
            v6_reg <= v5_reg;
        end
        if (rdy6) begin
            sec6_reg    <= sec5_reg;
            edge_reg[0] <= e0;
            edge_reg[1] <= e1;
            edge_reg[2] <= e2;
            cen_reg[0]  <= c0;
            cen_reg[1]  <= c1;
            cen_reg[2]  <= c2;
            dl_reg      <= dl_next;
        end
    end

    // stage 7: compare selection and saturation into the output register
    logic                 v7_reg;
    logic [OUT_W-1:0]     out_reg;
    logic [OUT_W-1:0]     out_next;
    logic signed [PW-1:0] lead_w;
    logic [15:0]          up_v   [3];
    logic [15:0]          down_v [3];
    logic [14:0]          duty_v [3];

    assign lead_w = $signed({{(PW-CFG_W){1'b0}}, adc_lead_reg});

    always_comb begin
        logic [1:0] e;
        for (int k = 0; k < 3; k++) begin
            e         = edge_sel(2'(k), sec6_reg);
            up_v[k]   = sat_s16(edge_reg[e] - dl_reg[e]);
            down_v[k] = sat_s16(edge_reg[e] + dl_reg[e]);
            duty_v[k] = sat_u15(cen_reg[e]);
        end
    end

    assign out_next = {duty_v[2], duty_v[1], duty_v[0],
                       down_v[2], down_v[1], down_v[0],
                       up_v[2], up_v[1], up_v[0],
                       sat_s16(edge_reg[2] - dl_reg[2] - lead_w),
                       sat_s16(edge_reg[1] - dl_reg[1] - lead_w),
                       sec6_reg};

    assign rdy7 = !v7_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (rdy7) begin
            v7_reg <= v6_reg;
        end
        if (rdy7) begin
            out_reg <= out_next;
        end
    end

    assign s_tready = rdy1;
    assign m_tvalid = v7_reg;
    assign m_tdata  = out_reg;

endmodule
`default_nettype wire

// ----- sv/svpwm_ss_chk.sv -----
`default_nettype none
module svpwm_ss_chk (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [175:0] m_tdata
);
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // zero vector: all phases sit at half period
    a_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == 3'd0 || m_tdata[2:0] == 3'd7) |->
        m_tdata[145:131] == 15'd8192 && m_tdata[160:146] == 15'd8192 &&
        m_tdata[175:161] == 15'd8192)
        else $error("zero vector duty mismatch");

endmodule

bind svpwm_single_shunt_phase_shift_top svpwm_ss_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
